// ===== design/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and character helpers for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

   // default width of the offset, row and column counters
   localparam int POSITION_BITS_DEFAULT = 16;

   // width of each reported position field
   localparam int FIELD_BITS = 16;
   localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

   // result queue depth and the free space one transfer may need
   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_RESULTS = 2;

   // character codes
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_ASTERISK  = 8'h2A;
   localparam logic [7:0] CHAR_LCURLY    = 8'h7B;
   localparam logic [7:0] CHAR_RCURLY    = 8'h7D;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHAR_LSQUARE   = 8'h5B;
   localparam logic [7:0] CHAR_RSQUARE   = 8'h5D;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;

   // token kinds
   typedef enum logic [3:0] {
      KIND_IDENT      = 4'd0,
      KIND_NUMBER     = 4'd1,
      KIND_STRING     = 4'd2,
      KIND_COMMA      = 4'd3,
      KIND_LPAREN     = 4'd4,
      KIND_RPAREN     = 4'd5,
      KIND_ASTERISK   = 4'd6,
      KIND_LCURLY     = 4'd7,
      KIND_RCURLY     = 4'd8,
      KIND_SEMICOLON  = 4'd9,
      KIND_LSQUARE    = 4'd10,
      KIND_RSQUARE    = 4'd11,
      KIND_PLUS       = 4'd12,
      KIND_EOF        = 4'd13,
      KIND_BAD_BYTE   = 4'd14,
      KIND_UNFINISHED = 4'd15
   } kind_type;

   // scan modes
   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_IDENT  = 5'b00010,
      MODE_NUMBER = 5'b00100,
      MODE_STRING = 5'b01000,
      MODE_HALTED = 5'b10000
   } mode_type;

   // one result item
   typedef struct packed {
      kind_type              token_kind;
      logic [FIELD_BITS-1:0] start_offset;
      logic [FIELD_BITS-1:0] token_length;
      logic [FIELD_BITS-1:0] start_row;
      logic [FIELD_BITS-1:0] start_col;
      logic                  last_of_run;
   } result_type;

   // results produced by one transfer, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   // punctuator kind, identifier kind when the byte is no punctuator
   function automatic kind_type punct_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         CHAR_COMMA:     k = KIND_COMMA;
         CHAR_LPAREN:    k = KIND_LPAREN;
         CHAR_RPAREN:    k = KIND_RPAREN;
         CHAR_ASTERISK:  k = KIND_ASTERISK;
         CHAR_LCURLY:    k = KIND_LCURLY;
         CHAR_RCURLY:    k = KIND_RCURLY;
         CHAR_SEMICOLON: k = KIND_SEMICOLON;
         CHAR_LSQUARE:   k = KIND_LSQUARE;
         CHAR_RSQUARE:   k = KIND_RSQUARE;
         CHAR_PLUS:      k = KIND_PLUS;
         default:        k = KIND_IDENT;
      endcase
      return k;
   endfunction

endpackage

// ===== design/stt_req_if.sv =====
// ----------------------------------------------------------------------------
// stt_req_if
// Input channel: one source byte or end marker per transfer.
// ----------------------------------------------------------------------------
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       is_end;

   modport source (output valid, output char_byte, output is_end, input ready);
   modport sink (input valid, input char_byte, input is_end, output ready);
endinterface

// ===== design/stt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// stt_rsp_if
// Result channel: one token per transfer.
// ----------------------------------------------------------------------------
interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [15:0] start_offset;
   logic [15:0] token_length;
   logic [15:0] start_row;
   logic [15:0] start_col;
   logic        last_of_run;

   modport source (output valid, output token_kind, output start_offset,
                   output token_length, output start_row, output start_col,
                   output last_of_run, input ready);
   modport sink (input valid, input token_kind, input start_offset,
                 input token_length, input start_row, input start_col,
                 input last_of_run, output ready);
endinterface

// ===== design/stt_scanner.sv =====
// ----------------------------------------------------------------------------
// stt_scanner
// Scan state and per-byte token logic; produces up to two results per
// accepted transfer.
// ----------------------------------------------------------------------------
module stt_scanner #(
   parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        char_byte,
   input  logic              is_end,
   output stt_pkg::push_type push
);

   localparam int WIDE_BITS = (POSITION_BITS > stt_pkg::FIELD_BITS) ?
                              POSITION_BITS : stt_pkg::FIELD_BITS;
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   stt_pkg::mode_type        mode_ff, mode_in;
   logic                     esc_ff, esc_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] col_ff, col_in;
   logic [POSITION_BITS-1:0] tpos_ff, tpos_in;
   logic [POSITION_BITS-1:0] tline_ff, tline_in;
   logic [POSITION_BITS-1:0] tcol_ff, tcol_in;

   function automatic logic [POSITION_BITS-1:0] sat_inc(
      input logic [POSITION_BITS-1:0] v);
      return (v == '1) ? v : v + POS_ONE;
   endfunction

   function automatic logic [stt_pkg::FIELD_BITS-1:0] clamp(
      input logic [POSITION_BITS-1:0] v);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(v);
      return (w > WIDE_BITS'(stt_pkg::FIELD_MAX)) ? stt_pkg::FIELD_MAX :
             w[stt_pkg::FIELD_BITS-1:0];
   endfunction

   function automatic stt_pkg::result_type make_result(
      input stt_pkg::kind_type k,
      input logic [POSITION_BITS-1:0] off,
      input logic [POSITION_BITS-1:0] len,
      input logic [POSITION_BITS-1:0] row,
      input logic [POSITION_BITS-1:0] col);
      stt_pkg::result_type r;
      r.token_kind   = k;
      r.start_offset = clamp(off);
      r.token_length = clamp(len);
      r.start_row    = clamp(row);
      r.start_col    = clamp(col);
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   // next scan state and results for the byte under transfer
   always_comb begin
      stt_pkg::result_type rs [2];
      stt_pkg::kind_type   pk;
      logic [1:0]          n;
      logic                run_idle;
      logic                more;
      logic                closes;

      mode_in  = mode_ff;
      esc_in   = esc_ff;
      pos_in   = pos_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      tpos_in  = tpos_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      rs[0]    = make_result(stt_pkg::KIND_EOF, '0, '0, '0, '0);
      rs[1]    = rs[0];
      n        = 2'd0;
      run_idle = 1'b0;
      more     = 1'b0;
      closes   = 1'b0;
      pk       = stt_pkg::punct_kind(char_byte);

      if (accept) begin
         if (is_end) begin
            // close any pending token, then back to reset state
            case (mode_ff)
               stt_pkg::MODE_IDENT, stt_pkg::MODE_NUMBER: begin
                  rs[0] = make_result((mode_ff == stt_pkg::MODE_IDENT) ?
                                      stt_pkg::KIND_IDENT : stt_pkg::KIND_NUMBER,
                                      tpos_ff, pos_ff - tpos_ff, tline_ff, tcol_ff);
                  rs[1] = make_result(stt_pkg::KIND_EOF, pos_ff, '0, line_ff, col_ff);
                  n = 2'd2;
               end
               stt_pkg::MODE_IDLE: begin
                  rs[0] = make_result(stt_pkg::KIND_EOF, pos_ff, '0, line_ff, col_ff);
                  n = 2'd1;
               end
               stt_pkg::MODE_STRING: begin
                  rs[0] = make_result(stt_pkg::KIND_UNFINISHED, tpos_ff, '0,
                                      tline_ff, tcol_ff);
                  n = 2'd1;
               end
               default: begin
                  n = 2'd0;
               end
            endcase
            mode_in  = stt_pkg::MODE_IDLE;
            esc_in   = 1'b0;
            pos_in   = '0;
            line_in  = POS_ONE;
            col_in   = POS_ONE;
            tpos_in  = '0;
            tline_in = POS_ONE;
            tcol_in  = POS_ONE;
         end else begin
            case (mode_ff)
               stt_pkg::MODE_IDLE: begin
                  run_idle = 1'b1;
               end
               stt_pkg::MODE_IDENT, stt_pkg::MODE_NUMBER: begin
                  more = stt_pkg::is_digit(char_byte) ||
                         (mode_ff == stt_pkg::MODE_IDENT && stt_pkg::is_letter(char_byte));
                  if (more) begin
                     pos_in = sat_inc(pos_ff);
                     col_in = sat_inc(col_ff);
                  end else begin
                     rs[0] = make_result((mode_ff == stt_pkg::MODE_IDENT) ?
                                         stt_pkg::KIND_IDENT : stt_pkg::KIND_NUMBER,
                                         tpos_ff, pos_ff - tpos_ff, tline_ff, tcol_ff);
                     n = 2'd1;
                     mode_in = stt_pkg::MODE_IDLE;
                     run_idle = 1'b1;
                  end
               end
               stt_pkg::MODE_STRING: begin
                  // closing quote counts in the lexeme
                  closes = (char_byte == stt_pkg::CHAR_QUOTE) && !esc_ff;
                  esc_in = (char_byte == stt_pkg::CHAR_BACKSLASH);
                  pos_in = sat_inc(pos_ff);
                  col_in = sat_inc(col_ff);
                  if (closes) begin
                     rs[0] = make_result(stt_pkg::KIND_STRING, tpos_ff,
                                         pos_in - tpos_ff, tline_ff, tcol_ff);
                     n = 2'd1;
                     mode_in = stt_pkg::MODE_IDLE;
                     esc_in = 1'b0;
                  end
               end
               default: begin
                  // halted: bytes ignored until the end marker
                  n = 2'd0;
               end
            endcase

            // byte seen between tokens
            if (run_idle) begin
               if (char_byte == stt_pkg::CHAR_SPACE || char_byte == stt_pkg::CHAR_TAB) begin
                  pos_in = sat_inc(pos_ff);
                  col_in = sat_inc(col_ff);
               end else if (char_byte == stt_pkg::CHAR_NEWLINE) begin
                  pos_in  = sat_inc(pos_ff);
                  line_in = sat_inc(line_ff);
                  col_in  = POS_ONE;
               end else if (pk != stt_pkg::KIND_IDENT) begin
                  rs[n[0]] = make_result(pk, pos_ff, POS_ONE, line_ff, col_ff);
                  n = n + 2'd1;
                  pos_in = sat_inc(pos_ff);
                  col_in = sat_inc(col_ff);
               end else if (char_byte == stt_pkg::CHAR_QUOTE ||
                            stt_pkg::is_letter(char_byte) ||
                            stt_pkg::is_digit(char_byte)) begin
                  tpos_in  = pos_ff;
                  tline_in = line_ff;
                  tcol_in  = col_ff;
                  esc_in   = 1'b0;
                  pos_in   = sat_inc(pos_ff);
                  col_in   = sat_inc(col_ff);
                  if (char_byte == stt_pkg::CHAR_QUOTE) begin
                     mode_in = stt_pkg::MODE_STRING;
                  end else if (stt_pkg::is_letter(char_byte)) begin
                     mode_in = stt_pkg::MODE_IDENT;
                  end else begin
                     mode_in = stt_pkg::MODE_NUMBER;
                  end
               end else begin
                  rs[n[0]] = make_result(stt_pkg::KIND_BAD_BYTE, pos_ff, '0,
                                         line_ff, col_ff);
                  n = n + 2'd1;
                  mode_in = stt_pkg::MODE_HALTED;
               end
            end
         end
      end

      // mark the final result of this transfer
      if (n == 2'd1) begin
         rs[0].last_of_run = 1'b1;
      end else if (n == 2'd2) begin
         rs[1].last_of_run = 1'b1;
      end

      push.count  = n;
      push.first  = rs[0];
      push.second = rs[1];
   end

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= stt_pkg::MODE_IDLE;
         esc_ff   <= 1'b0;
         pos_ff   <= '0;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         tpos_ff  <= '0;
         tline_ff <= POS_ONE;
         tcol_ff  <= POS_ONE;
      end else begin
         mode_ff  <= mode_in;
         esc_ff   <= esc_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tpos_ff  <= tpos_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
      end
   end

`ifndef SYNTHESIS
   // a token never starts beyond the current offset
   a_start_not_ahead: assert property (@(posedge clock) disable iff (reset)
      tpos_ff <= pos_ff)
      else $error("token start ahead of byte position");

   // with two results, only the second carries the run marker
   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (!push.first.last_of_run && push.second.last_of_run))
      else $error("run marker misplaced on two results");

   // an end marker always leaves the scanner at reset state
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && is_end) |=> (mode_ff == stt_pkg::MODE_IDLE && pos_ff == '0 &&
                              line_ff == POS_ONE && col_ff == POS_ONE))
      else $error("end marker did not restart the stream");
`endif

endmodule

// ===== design/stt_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// stt_rsp_queue
// Small result queue: takes up to two results per cycle, hands out one per
// transfer, and throttles the input side by its free space.
// ----------------------------------------------------------------------------
module stt_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  stt_pkg::push_type   push,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output stt_pkg::result_type out_data
);

   localparam int PTR_BITS = $clog2(stt_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(stt_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] READY_LIMIT =
      CNT_BITS'(stt_pkg::QUEUE_DEPTH - stt_pkg::MAX_RESULTS);

   stt_pkg::result_type mem [stt_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in;
   logic [PTR_BITS-1:0] rd_ff, rd_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                pop;
   logic [PTR_BITS-1:0] wr_next;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem[rd_ff];
   assign in_ready  = (count_ff <= READY_LIMIT);
   assign wr_next   = wr_ff + PTR_BITS'(1);

   // pointer and fill count update
   always_comb begin
      wr_in    = wr_ff + PTR_BITS'(push.count);
      rd_in    = pop ? rd_ff + PTR_BITS'(1) : rd_ff;
      count_in = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

`ifndef SYNTHESIS
   // fill never exceeds the storage
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(stt_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   // results only arrive while there is room for a full run
   a_push_with_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff <= READY_LIMIT))
      else $error("results pushed without room");

   // a transfer out with nothing arriving drops the fill by one
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> (count_ff == $past(count_ff) - CNT_BITS'(1)))
      else $error("fill count out of step");
`endif

endmodule

// ===== design/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer: source bytes in, tokens with position out.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one source byte per transfer, or an end marker
//   (is_end high) that closes the stream and restarts all counters.
//   rsp_bus carries tokens: kind, start offset, length, row, column, and
//   last_of_run on the final token caused by one input transfer.
//   A byte produces zero, one or two tokens; an end marker up to two.
// Timing:
//   A token is registered in the result queue before it appears on rsp_bus.
//   One byte is taken every cycle while the 4-entry result queue holds at
//   most two tokens; a byte giving two tokens leaves the queue as two
//   transfers through the single result port draining the queue.
// Reset and stall:
//   Synchronous reset empties the queue and starts a fresh stream at
//   offset 0, row 1, column 1. When the receiver holds rsp_bus.ready low
//   the queue fills and req_bus.ready drops once fewer than two slots are
//   free; nothing is lost.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
   parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   stt_req_if.sink    req_bus,
   stt_rsp_if.source  rsp_bus
);

   stt_pkg::push_type   push;
   stt_pkg::result_type head;
   logic                accept;

   assign accept = req_bus.valid && req_bus.ready;

   // byte scanning
   stt_scanner #(
      .POSITION_BITS (POSITION_BITS)
   ) u_scanner (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_byte (req_bus.char_byte),
      .is_end    (req_bus.is_end),
      .push      (push)
   );

   // result buffering
   stt_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .in_ready  (req_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (head)
   );

   // result payload
   assign rsp_bus.token_kind   = head.token_kind;
   assign rsp_bus.start_offset = head.start_offset;
   assign rsp_bus.token_length = head.token_length;
   assign rsp_bus.start_row    = head.start_row;
   assign rsp_bus.start_col    = head.start_col;
   assign rsp_bus.last_of_run  = head.last_of_run;

endmodule
